[hw/rtl/julia_escape_time_pixel_assert.svh]
// Assertion macros for the escape-time pixel engine checkers.
// The enclosing module provides i_clk and i_rst_n.
`ifndef JULIA_ESCAPE_TIME_PIXEL_ASSERT_SVH
`define JULIA_ESCAPE_TIME_PIXEL_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define JETP_AST_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define JETP_AST_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/jetp_pkg.sv]
package jetp_pkg;

    // Fixed-point format and field widths
    localparam int FRAC_BITS = 28;
    localparam int DIM_BITS  = 12;
    localparam int SCR_W     = DIM_BITS + 1;
    localparam int CNT_W     = 16;
    localparam int C_W       = 30;
    localparam int STEP_W    = 31;
    localparam int CFG_W     = 31;
    localparam int CFG_IDX_W = 3;

    // z holds [-8, 8) in signed fixed point
    localparam int Z_W    = FRAC_BITS + 4;
    localparam int PROD_W = 2 * Z_W;
    // squares saturate at 16.0
    localparam int SQ_W   = Z_W + 1;
    // magnitude of x*y after the fraction shift
    localparam int XY_W   = PROD_W - 1 - FRAC_BITS;
    // working width of the z update sums
    localparam int SUM_W  = XY_W + 3;

    localparam logic signed [Z_W-1:0] Z_MAX = {1'b0, {(Z_W-1){1'b1}}};
    localparam logic signed [Z_W-1:0] Z_MIN = {1'b1, {(Z_W-1){1'b0}}};

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_C_REAL   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_C_IMAG   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_X   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_Y   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd6;

    typedef struct packed {
        logic [DIM_BITS-1:0] col;
        logic [DIM_BITS-1:0] row;
    } t_pix_in;

    typedef struct packed {
        logic [SCR_W-1:0] screen_col;
        logic [SCR_W-1:0] screen_row;
        logic [CNT_W-1:0] iteration_count;
    } t_pix_out;

    typedef struct packed {
        logic signed [C_W-1:0] c_real;
        logic signed [C_W-1:0] c_imag;
        logic [STEP_W-1:0]     step_x;
        logic [STEP_W-1:0]     step_y;
        logic [CNT_W-1:0]      max_iter;
        logic [DIM_BITS-1:0]   origin_x;
        logic [DIM_BITS-1:0]   origin_y;
    } t_cfg;

    // One mapped pixel waiting for the iteration unit
    typedef struct packed {
        logic signed [Z_W-1:0] x0;
        logic signed [Z_W-1:0] y0;
        logic [SCR_W-1:0]      scol;
        logic [SCR_W-1:0]      srow;
    } t_job;

    localparam t_cfg CFG_RESET = '{
        c_real:   '0,
        c_imag:   '0,
        step_x:   31'd4194304,
        step_y:   31'd4194304,
        max_iter: 16'd256,
        origin_x: '0,
        origin_y: '0
    };

endpackage

[hw/rtl/jetp_front.sv]
module jetp_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    output logic             o_busy,
    input  jetp_pkg::t_pix_in i_pix,
    input  jetp_pkg::t_cfg   i_cfg,
    output logic             o_push,
    output jetp_pkg::t_job   o_job,
    input  logic             i_full
);
    import jetp_pkg::*;

    localparam int MAP_W = DIM_BITS + STEP_W + 1;
    localparam logic signed [MAP_W-1:0] MAP_TWO = MAP_W'(2) << FRAC_BITS;

    logic    r_vld;
    logic    n_vld;
    t_pix_in r_pix;
    logic    accept;

    // Map a window coordinate to -2 + d*step, saturated to the z range
    function automatic logic signed [Z_W-1:0] map_z(input logic [DIM_BITS-1:0] d,
                                                     input logic [STEP_W-1:0] s);
        logic [DIM_BITS+STEP_W-1:0] prod;
        logic signed [MAP_W-1:0]    sum;
        prod = (DIM_BITS+STEP_W)'(d) * (DIM_BITS+STEP_W)'(s);
        sum  = $signed({1'b0, prod}) - MAP_TWO;
        if (sum > MAP_W'(Z_MAX)) begin
            map_z = Z_MAX;
        end else if (sum < MAP_W'(Z_MIN)) begin
            map_z = Z_MIN;
        end else begin
            map_z = sum[Z_W-1:0];
        end
    endfunction

    // Hold the beat while the queue is full
    assign o_busy = r_vld & i_full;
    assign o_push = r_vld & ~i_full;
    assign accept = i_start & ~o_busy;
    assign n_vld  = accept | o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pix <= i_pix;
        end
    end

    // Start point and screen position
    always_comb begin
        o_job.x0   = map_z(r_pix.col, i_cfg.step_x);
        o_job.y0   = map_z(r_pix.row, i_cfg.step_y);
        o_job.scol = {1'b0, r_pix.col} + {1'b0, i_cfg.origin_x};
        o_job.srow = {1'b0, r_pix.row} + {1'b0, i_cfg.origin_y};
    end

endmodule

[hw/rtl/jetp_queue.sv]
module jetp_queue #(
    parameter int DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  jetp_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output jetp_pkg::t_job o_job
);
    import jetp_pkg::*;

    localparam int Q_PTR_W = $clog2(DEPTH);
    localparam int Q_CNT_W = $clog2(DEPTH + 1);

    t_job               r_mem [DEPTH];
    logic [Q_PTR_W-1:0] r_wptr;
    logic [Q_PTR_W-1:0] r_rptr;
    logic [Q_CNT_W-1:0] r_cnt;
    logic [Q_PTR_W-1:0] n_wptr;
    logic [Q_PTR_W-1:0] n_rptr;
    logic [Q_CNT_W-1:0] n_cnt;

    function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
        ptr_inc = (p == Q_PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full  = (r_cnt == Q_CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rptr];

    // Advance pointers and fill count
    always_comb begin
        n_wptr = i_push ? ptr_inc(r_wptr) : r_wptr;
        n_rptr = i_pop ? ptr_inc(r_rptr) : r_rptr;
        n_cnt  = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

endmodule

[hw/rtl/jetp_core.sv]
module jetp_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  jetp_pkg::t_cfg     i_cfg,
    input  logic               i_empty,
    input  jetp_pkg::t_job     i_job,
    output logic               o_pop,
    output logic               o_done,
    output jetp_pkg::t_pix_out o_res
);
    import jetp_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_core_st;

    localparam logic [SQ_W-1:0] SQ_CAP  = {1'b1, {(SQ_W-1){1'b0}}};
    localparam logic [SQ_W:0]   ESC_LIM = (SQ_W + 1)'(1) << (FRAC_BITS + 2);
    localparam int              SH_W    = PROD_W - FRAC_BITS;

    t_core_st              r_st, n_st;
    logic signed [Z_W-1:0] r_x, n_x;
    logic signed [Z_W-1:0] r_y, n_y;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic                  r_first, n_first;
    logic [SCR_W-1:0]      r_scol, n_scol;
    logic [SCR_W-1:0]      r_srow, n_srow;
    logic                  r_done, n_done;
    t_pix_out              r_res, n_res;

    logic [Z_W-1:0]          mag_x, mag_y;
    logic [PROD_W-1:0]       p_xx, p_yy, p_xy;
    logic [SH_W-1:0]         sh_xx, sh_yy;
    logic [SQ_W-1:0]         sq_x, sq_y;
    logic [SUM_W-1:0]        xy_e;
    logic signed [SUM_W-1:0] xy_s;
    logic signed [SUM_W-1:0] nx_sum, ny_sum;
    logic [SQ_W:0]           esc_sum;
    logic                    finish;

    function automatic logic signed [Z_W-1:0] sat_z(input logic signed [SUM_W-1:0] v);
        if (v > SUM_W'(Z_MAX)) begin
            sat_z = Z_MAX;
        end else if (v < SUM_W'(Z_MIN)) begin
            sat_z = Z_MIN;
        end else begin
            sat_z = v[Z_W-1:0];
        end
    endfunction

    // Squares and cross product of the current z, sign and magnitude form
    always_comb begin
        mag_x  = r_x[Z_W-1] ? (~r_x + 1'b1) : r_x;
        mag_y  = r_y[Z_W-1] ? (~r_y + 1'b1) : r_y;
        p_xx   = PROD_W'(mag_x) * PROD_W'(mag_x);
        p_yy   = PROD_W'(mag_y) * PROD_W'(mag_y);
        p_xy   = PROD_W'(mag_x) * PROD_W'(mag_y);
        sh_xx  = p_xx[PROD_W-1:FRAC_BITS];
        sh_yy  = p_yy[PROD_W-1:FRAC_BITS];
        sq_x   = (sh_xx > SH_W'(SQ_CAP)) ? SQ_CAP : sh_xx[SQ_W-1:0];
        sq_y   = (sh_yy > SH_W'(SQ_CAP)) ? SQ_CAP : sh_yy[SQ_W-1:0];
        xy_e   = {{(SUM_W-XY_W){1'b0}}, p_xy[FRAC_BITS+XY_W-1:FRAC_BITS]};
        xy_s   = (r_x[Z_W-1] ^ r_y[Z_W-1]) ? -$signed(xy_e) : $signed(xy_e);
        nx_sum = $signed(SUM_W'(sq_x)) - $signed(SUM_W'(sq_y))
                 + SUM_W'($signed(i_cfg.c_real));
        ny_sum = (xy_s <<< 1) + SUM_W'($signed(i_cfg.c_imag));
        esc_sum = {1'b0, sq_x} + {1'b0, sq_y};
    end

    // Stop on escape or limit, tested on the z of the last iteration
    assign finish = (r_st == ST_RUN) && !r_first
                    && ((esc_sum >= ESC_LIM) || (r_cnt >= i_cfg.max_iter));
    assign o_pop  = (r_st == ST_IDLE) && !i_empty;

    always_comb begin
        n_st    = r_st;
        n_x     = r_x;
        n_y     = r_y;
        n_cnt   = r_cnt;
        n_first = r_first;
        n_scol  = r_scol;
        n_srow  = r_srow;
        n_done  = 1'b0;
        n_res   = r_res;
        case (r_st)
            ST_IDLE: begin
                // Load the next mapped pixel
                if (!i_empty) begin
                    n_x     = i_job.x0;
                    n_y     = i_job.y0;
                    n_scol  = i_job.scol;
                    n_srow  = i_job.srow;
                    n_cnt   = '0;
                    n_first = 1'b1;
                    n_st    = ST_RUN;
                end
            end
            ST_RUN: begin
                if (finish) begin
                    n_done = 1'b1;
                    n_res  = '{screen_col: r_scol, screen_row: r_srow,
                               iteration_count: r_cnt};
                    n_st   = ST_IDLE;
                end else begin
                    // Advance z = z^2 + c
                    n_x     = sat_z(nx_sum);
                    n_y     = sat_z(ny_sum);
                    n_cnt   = r_cnt + 1'b1;
                    n_first = 1'b0;
                end
            end
            default: begin
                n_st = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= ST_IDLE;
            r_done <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x     <= n_x;
        r_y     <= n_y;
        r_cnt   <= n_cnt;
        r_first <= n_first;
        r_scol  <= n_scol;
        r_srow  <= n_srow;
        r_res   <= n_res;
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

[hw/rtl/julia_escape_time_pixel.sv]
// Channel   Direction  Handshake                    Beat
// --------  ---------  ---------------------------  ---------------------------------
// pixel     in         i_start high, o_busy low     i_pix: col, row
// result    out        o_done, one-cycle strobe     o_res: screen_col, screen_row,
//                                                   iteration_count
// config    in         i_cfg_we                     i_cfg_idx, i_cfg_wdata
//
// One z = z^2 + c iteration per cycle in the core's squaring unit; a pixel holds
// the core through a load step, its iterations and a final escape test.
// The front register and the QUEUE_DEPTH queue let new pixels be taken while the
// core iterates; o_busy rises only when both are full.
// Synchronous active-low reset clears control state and loads register defaults.
// Results cannot be stalled; each strobe lasts exactly one cycle.
module julia_escape_time_pixel #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    output logic                            o_busy,
    input  jetp_pkg::t_pix_in               i_pix,
    output logic                            o_done,
    output jetp_pkg::t_pix_out              o_res,
    input  logic                            i_cfg_we,
    input  logic [jetp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [jetp_pkg::CFG_W-1:0]      i_cfg_wdata
);
    import jetp_pkg::*;

    t_cfg r_cfg, n_cfg;
    logic push, pop, full, empty;
    t_job job_in, job_out;

    // Write configuration registers; unknown indexes drop
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_C_REAL:   n_cfg.c_real   = i_cfg_wdata[C_W-1:0];
                CFG_C_IMAG:   n_cfg.c_imag   = i_cfg_wdata[C_W-1:0];
                CFG_STEP_X:   n_cfg.step_x   = i_cfg_wdata[STEP_W-1:0];
                CFG_STEP_Y:   n_cfg.step_y   = i_cfg_wdata[STEP_W-1:0];
                CFG_MAX_ITER: n_cfg.max_iter = i_cfg_wdata[CNT_W-1:0];
                CFG_ORIGIN_X: n_cfg.origin_x = i_cfg_wdata[DIM_BITS-1:0];
                CFG_ORIGIN_Y: n_cfg.origin_y = i_cfg_wdata[DIM_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    jetp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .o_busy  (o_busy),
        .i_pix   (i_pix),
        .i_cfg   (r_cfg),
        .o_push  (push),
        .o_job   (job_in),
        .i_full  (full)
    );

    jetp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_job   (job_out)
    );

    jetp_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_empty (empty),
        .i_job   (job_out),
        .o_pop   (pop),
        .o_done  (o_done),
        .o_res   (o_res)
    );

endmodule

[hw/rtl/jetp_checker.sv]
`include "julia_escape_time_pixel_assert.svh"

module jetp_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_start,
    input logic                            o_busy,
    input logic                            o_done,
    input jetp_pkg::t_pix_out              o_res
);

    // The core returns to idle after each result, so strobes never abut
    `JETP_AST_NXT(a_strobe_single, o_done, !o_done, "result strobe held past one cycle")

    // Every pixel runs at least one iteration
    `JETP_AST_IMP(a_count_nonzero, o_done, o_res.iteration_count != '0, "zero iteration count")

    // Busy only appears after a beat was taken into a full pipeline
    `JETP_AST_IMP(a_busy_rise, $rose(o_busy), $past(i_start), "busy rose without a beat")

endmodule

bind julia_escape_time_pixel jetp_checker u_jetp_checker (.*);
